FILE: src/pwmpdc_pkg.sv
// ----------------------------------------------------------------------------
// pwmpdc_pkg
// Shared widths, constants and pipeline stage types for the PWM prescaler,
// period and duty calculator.
// ----------------------------------------------------------------------------
package pwmpdc_pkg;

  localparam int NUM_PRESCALERS   = 8;
  localparam int MAX_COUNTER_BITS = 24;

  localparam int CLK_W   = 27;
  localparam int FREQ_W  = 16;
  localparam int DUTY_W  = 16;
  localparam int BITS_W  = 5;
  localparam int IDX_W   = 3;
  localparam int TOP_W   = 24;
  localparam int SHIFT_W = 4;
  localparam int PROD_W  = DUTY_W + TOP_W + 1;
  localparam int CMP_W   = (MAX_COUNTER_BITS > CLK_W) ? MAX_COUNTER_BITS : CLK_W;

  // one quotient bit per divider stage
  localparam int DIV_STEPS = CLK_W;

  localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(60000000);
  localparam logic [TOP_W-1:0]  TOP_MAX     = {TOP_W{1'b1}};
  localparam logic [DUTY_W-1:0] DUTY_HALF   = {1'b1, {(DUTY_W-1){1'b0}}};

  // prescaler divide 1,2,4,8,16,64,256,1024 as right shifts
  localparam logic [SHIFT_W-1:0] PRESC_SHIFT [0:7] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10
  };

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              found;
    logic [BITS_W-1:0] bits;
    logic              force_full;
    logic              disabled;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    logic [FREQ_W-1:0] rem;
    logic [CLK_W-1:0]  dq;      // dividend shifts out, quotient shifts in
  } div_stage_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              found;
    logic              disabled;
    logic [DUTY_W-1:0] duty;
    logic [TOP_W-1:0]  top;
    logic [TOP_W:0]    top_p1;
  } top_stage_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              found;
    logic              disabled;
    logic [TOP_W-1:0]  top;
    logic [PROD_W-1:0] prod;
  } mul_stage_t;

endpackage

FILE: src/pwmpdc_if.sv
// ----------------------------------------------------------------------------
// pwmpdc channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface pwmpdc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] freq_hz;
  logic [15:0] duty;
  logic [4:0]  counter_bits;
  logic        full_top;

  modport source (output valid, output freq_hz, output duty, output counter_bits,
                  output full_top, input ready);
  modport sink   (input valid, input freq_hz, input duty, input counter_bits,
                  input full_top, output ready);
endinterface

interface pwmpdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  prescaler_index;
  logic [23:0] period_top;
  logic [23:0] compare_value;
  logic        out_of_range;
  logic        disabled;

  modport source (output valid, output prescaler_index, output period_top,
                  output compare_value, output out_of_range, output disabled,
                  input ready);
  modport sink   (input valid, input prescaler_index, input period_top,
                  input compare_value, input out_of_range, input disabled,
                  output ready);
endinterface

FILE: src/pwm_prescaler_period_duty_calc_core.sv
// ----------------------------------------------------------------------------
// pwm_prescaler_period_duty_calc_core
// Prescaler pick, period top by pipelined restoring division, and compare
// value by multiply with round-half-even, one request word per cycle unless a full pipe sits behind a stalled output.
// ----------------------------------------------------------------------------
// Pipeline from input accept to out valid: 1 prescaler select stage,
//   27 divider stages at one quotient bit each, top, multiply, round/output.
// Throughput: one word per cycle; every stage advances on its own, so bubbles
//   are squeezed out and only a full pipe behind a stalled output holds input.
// Reset (rst_n low, synchronous): all valid bits clear, clock_hz = 60000000.
module pwm_prescaler_period_duty_calc_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pwmpdc_pkg::CLK_W-1:0] cfg_wr_data,
  pwmpdc_in_if.sink                   in_ch,
  pwmpdc_out_if.source                out_ch
);
  import pwmpdc_pkg::*;

  logic [CLK_W-1:0] clock_hz_r;

  div_stage_t div_r     [0:DIV_STEPS];
  div_stage_t div_nxt   [0:DIV_STEPS];
  logic       div_v_r   [0:DIV_STEPS];
  logic       div_rdy   [0:DIV_STEPS];

  top_stage_t tp_r, tp_nxt;
  logic       tp_v_r, tp_rdy;
  mul_stage_t mp_r, mp_nxt;
  logic       mp_v_r, mp_rdy;

  logic [IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic [TOP_W-1:0] o_top_r, o_top_nxt;
  logic [TOP_W-1:0] o_cmp_r, o_cmp_nxt;
  logic             o_oor_r, o_oor_nxt;
  logic             o_dis_r, o_dis_nxt;
  logic             o_v_r, o_rdy;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_RESET;
    end else if (cfg_wr_en) begin
      clock_hz_r <= cfg_wr_data;
    end
  end

  // ready chain: a stage loads when empty or when its successor moves on
  assign o_rdy  = !o_v_r  || out_ch.ready;
  assign mp_rdy = !mp_v_r || o_rdy;
  assign tp_rdy = !tp_v_r || mp_rdy;
  assign div_rdy[DIV_STEPS] = !div_v_r[DIV_STEPS] || tp_rdy;
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_rdy
    assign div_rdy[k] = !div_v_r[k] || div_rdy[k+1];
  end
  assign in_ch.ready = div_rdy[0];

  // stage 0: saturate counter width, find first prescaler that fits
  always_comb begin
    logic [BITS_W-1:0]  bits_sat;
    logic [SHIFT_W+1:0] tot_sh;
    logic [CLK_W-1:0]   reach;
    logic [IDX_W-1:0]   sel;
    logic               fit;
    bits_sat = (int'(in_ch.counter_bits) > MAX_COUNTER_BITS) ?
               BITS_W'(MAX_COUNTER_BITS) : in_ch.counter_bits;
    sel = IDX_W'(NUM_PRESCALERS - 1);
    fit = 1'b0;
    // walk from the largest down so the smallest fitting one wins
    for (int i = NUM_PRESCALERS - 1; i >= 0; i--) begin
      tot_sh = (SHIFT_W+2)'(PRESC_SHIFT[i]) + (SHIFT_W+2)'(bits_sat);
      reach  = clock_hz_r >> tot_sh;
      if (reach <= CLK_W'(in_ch.freq_hz)) begin
        sel = IDX_W'(i);
        fit = 1'b1;
      end
    end
    div_nxt[0].idx        = sel;
    div_nxt[0].found      = fit;
    div_nxt[0].bits       = bits_sat;
    div_nxt[0].force_full = in_ch.full_top;
    div_nxt[0].disabled   = (in_ch.freq_hz == '0);
    div_nxt[0].freq       = in_ch.freq_hz;
    div_nxt[0].duty       = in_ch.duty;
    div_nxt[0].rem        = '0;
    div_nxt[0].dq         = clock_hz_r >> PRESC_SHIFT[sel];
  end

  // divider: one restoring step per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_comb begin
      logic [FREQ_W:0] rem_sh;
      logic [FREQ_W:0] diff;
      logic            ge;
      rem_sh = {div_r[k-1].rem, div_r[k-1].dq[CLK_W-1]};
      diff   = rem_sh - {1'b0, div_r[k-1].freq};
      ge     = (rem_sh >= {1'b0, div_r[k-1].freq});
      div_nxt[k]     = div_r[k-1];
      div_nxt[k].rem = ge ? diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
      div_nxt[k].dq  = {div_r[k-1].dq[CLK_W-2:0], ge};
    end
  end

  for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k] <= 1'b0;
      end else if (div_rdy[k]) begin
        div_v_r[k] <= (k == 0) ? in_ch.valid : div_v_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (div_rdy[k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // top: quotient - 1 (0 stays 0), clamp to counter and field range; counter max on no fit or full_top
  always_comb begin
    logic [MAX_COUNTER_BITS:0]   lim_w;
    logic [MAX_COUNTER_BITS-1:0] lim;
    logic [CMP_W-1:0]            q_ext;
    logic [CMP_W-1:0]            qm1;
    logic [CMP_W-1:0]            sel_top;
    lim_w = ({{MAX_COUNTER_BITS{1'b0}}, 1'b1} << div_r[DIV_STEPS].bits)
            - {{MAX_COUNTER_BITS{1'b0}}, 1'b1};
    lim   = lim_w[MAX_COUNTER_BITS-1:0];
    q_ext = CMP_W'(div_r[DIV_STEPS].dq);
    qm1   = (q_ext == '0) ? '0 : q_ext - CMP_W'(1);
    if (!div_r[DIV_STEPS].found || div_r[DIV_STEPS].force_full ||
        qm1 > CMP_W'(lim)) begin
      sel_top = CMP_W'(lim);
    end else begin
      sel_top = qm1;
    end
    tp_nxt.idx      = div_r[DIV_STEPS].idx;
    tp_nxt.found    = div_r[DIV_STEPS].found;
    tp_nxt.disabled = div_r[DIV_STEPS].disabled;
    tp_nxt.duty     = div_r[DIV_STEPS].duty;
    tp_nxt.top      = (sel_top > CMP_W'(TOP_MAX)) ? TOP_MAX : sel_top[TOP_W-1:0];
    tp_nxt.top_p1   = {1'b0, tp_nxt.top} + (TOP_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_v_r <= 1'b0;
    end else if (tp_rdy) begin
      tp_v_r <= div_v_r[DIV_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (tp_rdy) begin
      tp_r <= tp_nxt;
    end
  end

  // multiply duty by period length
  always_comb begin
    mp_nxt.idx      = tp_r.idx;
    mp_nxt.found    = tp_r.found;
    mp_nxt.disabled = tp_r.disabled;
    mp_nxt.top      = tp_r.top;
    mp_nxt.prod     = PROD_W'(tp_r.duty) * PROD_W'(tp_r.top_p1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_v_r <= 1'b0;
    end else if (mp_rdy) begin
      mp_v_r <= tp_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (mp_rdy) begin
      mp_r <= mp_nxt;
    end
  end

  // round half to even, saturate to top; zero frequency clears index, top, compare and out-of-range
  always_comb begin
    logic [TOP_W:0]    q;
    logic [DUTY_W-1:0] r;
    logic              inc;
    logic [TOP_W:0]    qr;
    q   = mp_r.prod[PROD_W-1:DUTY_W];
    r   = mp_r.prod[DUTY_W-1:0];
    inc = (r > DUTY_HALF) || ((r == DUTY_HALF) && q[0]);
    qr  = q + (TOP_W+1)'(inc);
    if (mp_r.disabled) begin
      o_idx_nxt = '0;
      o_top_nxt = '0;
      o_cmp_nxt = '0;
      o_oor_nxt = 1'b0;
    end else begin
      o_idx_nxt = mp_r.idx;
      o_top_nxt = mp_r.top;
      o_cmp_nxt = (qr > {1'b0, mp_r.top}) ? mp_r.top : qr[TOP_W-1:0];
      o_oor_nxt = !mp_r.found;
    end
    o_dis_nxt = mp_r.disabled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= mp_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_idx_r <= o_idx_nxt;
      o_top_r <= o_top_nxt;
      o_cmp_r <= o_cmp_nxt;
      o_oor_r <= o_oor_nxt;
      o_dis_r <= o_dis_nxt;
    end
  end

  assign out_ch.valid           = o_v_r;
  assign out_ch.prescaler_index = o_idx_r;
  assign out_ch.period_top      = o_top_r;
  assign out_ch.compare_value   = o_cmp_r;
  assign out_ch.out_of_range    = o_oor_r;
  assign out_ch.disabled        = o_dis_r;

`ifndef SYNTHESIS
  // input only blocks when the output word is held back
  a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output backpressure");

  a_cmp_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.compare_value <= out_ch.period_top))
    else $error("compare value above period top");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.disabled) |->
      (out_ch.period_top == '0 && out_ch.compare_value == '0 &&
       out_ch.prescaler_index == '0 && !out_ch.out_of_range))
    else $error("disabled word carries nonzero fields");

  a_fallback_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_of_range) |->
      (out_ch.prescaler_index == IDX_W'(NUM_PRESCALERS - 1)))
    else $error("fallback did not use the last prescaler");
`endif

endmodule
